// ===== design/rhsv_pkg.sv =====
package rhsv_pkg;

  localparam int COMPONENT_BITS_DEF = 8;
  localparam int FRACTION_BITS_DEF  = 16;
  localparam int COMP_MAX_W         = 16;

  typedef logic [7:0]  comp_t;
  typedef logic [15:0] hue_t;
  typedef logic [15:0] sat_t;
  typedef logic [7:0]  bright_t;
  typedef logic [COMP_MAX_W-1:0] wcomp_t;

  // per-stage control: valid plus the two special cases
  typedef struct packed {
    logic valid;
    logic black;  // max is zero
    logic grey;   // max equals min
  } ctl_t;

  function automatic wcomp_t max3(wcomp_t a, wcomp_t b, wcomp_t c);
    wcomp_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic wcomp_t min3(wcomp_t a, wcomp_t b, wcomp_t c);
    wcomp_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

// ===== design/rgb_to_hsv_converter.sv =====
// RGB to HSV pixel converter, fully pipelined.
// Input channel: in_red/in_green/in_blue; a transaction is taken at a rising
// edge with start high and busy low. busy is always low, so one pixel can be
// taken every clock cycle.
// Result channel: out_hue, out_hue_undefined, out_saturation, out_brightness,
// qualified by out_valid for exactly one cycle. The receiver cannot stall;
// nothing here waits on it, results simply flow out in input order.
// Two prep stages (max/min, then delta and dividend setup) are followed by
// FRACTION_BITS restoring division stages, one quotient bit per stage,
// running the saturation and hue divisions side by side. Throughput: one
// pixel per cycle.
// Reset (rst_n low, synchronous) clears every stage valid bit; pixels in
// flight are dropped and no result appears until new transactions arrive.
// Black pixel: saturation 0, hue undefined. Grey pixel: hue undefined, hue 0.
module rgb_to_hsv_converter #(
  parameter int COMPONENT_BITS = rhsv_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = rhsv_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rhsv_pkg::comp_t   in_red,
  input  rhsv_pkg::comp_t   in_green,
  input  rhsv_pkg::comp_t   in_blue,
  output logic              out_valid,
  output rhsv_pkg::hue_t    out_hue,
  output logic              out_hue_undefined,
  output rhsv_pkg::sat_t    out_saturation,
  output rhsv_pkg::bright_t out_brightness
);

  localparam int CB  = COMPONENT_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int HW  = CB + 3;
  localparam int LAT = FB + 2;

  // never back-pressures
  assign busy = 1'b0;

  // components at the internal width (upper bits dropped or zero-filled)
  logic [CB-1:0] in_r_c, in_g_c, in_b_c;
  assign in_r_c = CB'(in_red);
  assign in_g_c = CB'(in_green);
  assign in_b_c = CB'(in_blue);

  // stage taps: index 0 is the prep output, index FB the last divider step
  rhsv_pkg::ctl_t ctl_s     [0:FB];
  logic [CB-1:0]  mx_s      [0:FB];
  logic [CB-1:0]  sat_rem_s [0:FB];
  logic [FB-1:0]  sat_lo_s  [0:FB];
  logic [FB-1:0]  sat_q_s   [0:FB];
  logic [HW-1:0]  hue_rem_s [0:FB];
  logic [HW-1:0]  hue_den_s [0:FB];
  logic [FB-1:0]  hue_q_s   [0:FB];

  rhsv_prep #(
    .CB (CB),
    .FB (FB)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (start & ~busy),
    .red_i     (in_r_c),
    .green_i   (in_g_c),
    .blue_i    (in_b_c),
    .ctl_o     (ctl_s[0]),
    .mx_o      (mx_s[0]),
    .sat_rem_o (sat_rem_s[0]),
    .sat_lo_o  (sat_lo_s[0]),
    .hue_rem_o (hue_rem_s[0]),
    .hue_den_o (hue_den_s[0])
  );

  // quotients fill in from the LSB end; start-up contents shift out
  assign sat_q_s[0] = '0;
  assign hue_q_s[0] = '0;

  for (genvar k = 0; k < FB; k++) begin : g_div
    rhsv_div_stage #(
      .CB (CB),
      .FB (FB)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl_s[k]),
      .mx_i      (mx_s[k]),
      .sat_rem_i (sat_rem_s[k]),
      .sat_lo_i  (sat_lo_s[k]),
      .sat_q_i   (sat_q_s[k]),
      .hue_rem_i (hue_rem_s[k]),
      .hue_den_i (hue_den_s[k]),
      .hue_q_i   (hue_q_s[k]),
      .ctl_o     (ctl_s[k+1]),
      .mx_o      (mx_s[k+1]),
      .sat_rem_o (sat_rem_s[k+1]),
      .sat_lo_o  (sat_lo_s[k+1]),
      .sat_q_o   (sat_q_s[k+1]),
      .hue_rem_o (hue_rem_s[k+1]),
      .hue_den_o (hue_den_s[k+1]),
      .hue_q_o   (hue_q_s[k+1])
    );
  end

  // final override of the special cases; the remainders are unused here
  assign out_valid         = ctl_s[FB].valid;
  assign out_hue_undefined = ctl_s[FB].grey;
  assign out_hue           = ctl_s[FB].grey  ? '0 : rhsv_pkg::hue_t'(hue_q_s[FB]);
  assign out_saturation    = ctl_s[FB].black ? '0 : rhsv_pkg::sat_t'(sat_q_s[FB]);
  assign out_brightness    = rhsv_pkg::bright_t'(mx_s[FB]);

  // reference values for checking, taken from the input side
  logic [CB-1:0] chk_max;
  assign chk_max = CB'(rhsv_pkg::max3(rhsv_pkg::wcomp_t'(in_r_c), rhsv_pkg::wcomp_t'(in_g_c),
                                      rhsv_pkg::wcomp_t'(in_b_c)));

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted pixel did not come out after the pipeline latency");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching accepted pixel");

  a_brightness: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_brightness == rhsv_pkg::bright_t'($past(chk_max, LAT))))
    else $error("brightness does not match the max of the pixel taken");

  a_grey_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue_undefined ==
                   (($past(in_r_c, LAT) == $past(in_g_c, LAT)) &&
                    ($past(in_g_c, LAT) == $past(in_b_c, LAT)))))
    else $error("hue undefined flag does not match a grey pixel");

endmodule

// ===== design/rhsv_prep.sv =====
module rhsv_prep #(
  parameter int CB = rhsv_pkg::COMPONENT_BITS_DEF,
  parameter int FB = rhsv_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [CB-1:0]    red_i,
  input  logic [CB-1:0]    green_i,
  input  logic [CB-1:0]    blue_i,
  output rhsv_pkg::ctl_t   ctl_o,
  output logic [CB-1:0]    mx_o,
  output logic [CB-1:0]    sat_rem_o,
  output logic [FB-1:0]    sat_lo_o,
  output logic [CB+2:0]    hue_rem_o,
  output logic [CB+2:0]    hue_den_o
);

  localparam int HW = CB + 3;
  localparam int NW = CB + FB;

  // stage 1: max / min
  logic          v1_r;
  logic [CB-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  logic [CB-1:0] mx1_nxt, mn1_nxt;

  always_comb begin
    mx1_nxt = CB'(rhsv_pkg::max3(rhsv_pkg::wcomp_t'(red_i), rhsv_pkg::wcomp_t'(green_i),
                                 rhsv_pkg::wcomp_t'(blue_i)));
    mn1_nxt = CB'(rhsv_pkg::min3(rhsv_pkg::wcomp_t'(red_i), rhsv_pkg::wcomp_t'(green_i),
                                 rhsv_pkg::wcomp_t'(blue_i)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    r1_r  <= red_i;
    g1_r  <= green_i;
    b1_r  <= blue_i;
    mx1_r <= mx1_nxt;
    mn1_r <= mn1_nxt;
  end

  // stage 2: delta, sector offset, dividend setup
  logic [CB-1:0] delta;
  logic [HW-1:0] d_w, base, h6_nxt, d6_nxt, x_w, y_w;
  logic [NW-1:0] sat_num;
  rhsv_pkg::ctl_t ctl_nxt;

  always_comb begin
    delta = mx1_r - mn1_r;
    d_w   = HW'(delta);
    d6_nxt = (d_w << 2) + (d_w << 1);
    // h6 = sector*delta + x - y, always in [0, 6*delta), so mod 2^HW is exact
    if (r1_r == mx1_r) begin
      x_w  = HW'(g1_r);
      y_w  = HW'(b1_r);
      base = (g1_r >= b1_r) ? '0 : d6_nxt;
    end else if (g1_r == mx1_r) begin
      x_w  = HW'(b1_r);
      y_w  = HW'(r1_r);
      base = d_w << 1;
    end else begin
      x_w  = HW'(r1_r);
      y_w  = HW'(g1_r);
      base = d_w << 2;
    end
    h6_nxt  = base + x_w - y_w;
    // delta * (2^FB - 1)
    sat_num = (NW'(delta) << FB) - NW'(delta);
    ctl_nxt.valid = v1_r;
    ctl_nxt.black = (mx1_r == '0);
    ctl_nxt.grey  = (delta == '0);
  end

  rhsv_pkg::ctl_t ctl_r;
  logic [CB-1:0]  mx_r, sat_rem_r;
  logic [FB-1:0]  sat_lo_r;
  logic [HW-1:0]  hue_rem_r, hue_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r      <= mx1_r;
    sat_rem_r <= sat_num[NW-1:FB];
    sat_lo_r  <= sat_num[FB-1:0];
    hue_rem_r <= h6_nxt;
    hue_den_r <= d6_nxt;
  end

  assign ctl_o     = ctl_r;
  assign mx_o      = mx_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_lo_o  = sat_lo_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_den_o = hue_den_r;

endmodule

// ===== design/rhsv_div_stage.sv =====
module rhsv_div_stage #(
  parameter int CB = rhsv_pkg::COMPONENT_BITS_DEF,
  parameter int FB = rhsv_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rhsv_pkg::ctl_t ctl_i,
  input  logic [CB-1:0]  mx_i,
  input  logic [CB-1:0]  sat_rem_i,
  input  logic [FB-1:0]  sat_lo_i,
  input  logic [FB-1:0]  sat_q_i,
  input  logic [CB+2:0]  hue_rem_i,
  input  logic [CB+2:0]  hue_den_i,
  input  logic [FB-1:0]  hue_q_i,
  output rhsv_pkg::ctl_t ctl_o,
  output logic [CB-1:0]  mx_o,
  output logic [CB-1:0]  sat_rem_o,
  output logic [FB-1:0]  sat_lo_o,
  output logic [FB-1:0]  sat_q_o,
  output logic [CB+2:0]  hue_rem_o,
  output logic [CB+2:0]  hue_den_o,
  output logic [FB-1:0]  hue_q_o
);

  localparam int HW = CB + 3;

  // one restoring step for each divider; sat divides by max
  logic [CB:0]   sat_try, sat_dif;
  logic [HW:0]   hue_try, hue_dif;
  logic          sat_ge, hue_ge;
  logic [CB-1:0] sat_rem_nxt;
  logic [HW-1:0] hue_rem_nxt;

  always_comb begin
    sat_try = {sat_rem_i, sat_lo_i[FB-1]};
    sat_dif = sat_try - {1'b0, mx_i};
    sat_ge  = (sat_try >= {1'b0, mx_i});
    sat_rem_nxt = sat_ge ? sat_dif[CB-1:0] : sat_try[CB-1:0];
    hue_try = {hue_rem_i, 1'b0};
    hue_dif = hue_try - {1'b0, hue_den_i};
    hue_ge  = (hue_try >= {1'b0, hue_den_i});
    hue_rem_nxt = hue_ge ? hue_dif[HW-1:0] : hue_try[HW-1:0];
  end

  rhsv_pkg::ctl_t ctl_r;
  logic [CB-1:0]  mx_r, sat_rem_r;
  logic [FB-1:0]  sat_lo_r, sat_q_r, hue_q_r;
  logic [HW-1:0]  hue_rem_r, hue_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    mx_r      <= mx_i;
    sat_rem_r <= sat_rem_nxt;
    sat_lo_r  <= {sat_lo_i[FB-2:0], 1'b0};
    sat_q_r   <= {sat_q_i[FB-2:0], sat_ge};
    hue_rem_r <= hue_rem_nxt;
    hue_den_r <= hue_den_i;
    hue_q_r   <= {hue_q_i[FB-2:0], hue_ge};
  end

  assign ctl_o     = ctl_r;
  assign mx_o      = mx_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_lo_o  = sat_lo_r;
  assign sat_q_o   = sat_q_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_den_o = hue_den_r;
  assign hue_q_o   = hue_q_r;

endmodule
